// ----- rtl/cipu_pkg.sv -----
package cipu_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned PosW = 9;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned TrigW = 17;
  localparam logic [ScaleW-1:0] ScaleReset = 16'd32768;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRead = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRad   = 8'b0000_0010,
    StCos   = 8'b0000_0100,
    StSin   = 8'b0000_1000,
    StFetch = 8'b0001_0000,
    StAcc   = 8'b0010_0000,
    StDone  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

endpackage

// ----- rtl/cipu_trig_rom.sv -----
module cipu_trig_rom import cipu_pkg::*; #(
  parameter int unsigned ImgSize = 512,
  parameter int unsigned AngW = 9
) (
  input  logic                    clk_i,
  input  logic [AngW-1:0]         ang_i,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);

  // Q1.15 sine by the truncated Horner series over a quarter turn
  function automatic logic signed [TrigW-1:0] qsin(longint unsigned t);
    longint unsigned x, x2, acc;
    x = (t * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    acc = 64'd1 << 30;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd156;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd110;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd72;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd42;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd20;
    acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd6;
    acc = (x * acc) >> 30;
    return TrigW'((acc + 64'd16384) >> 15);
  endfunction

  function automatic logic signed [2*TrigW-1:0] trig_entry(int unsigned k);
    longint unsigned p, t;
    logic signed [TrigW-1:0] s, c, co, si;
    logic [1:0] q;
    p = (longint'(k) << 32) / ImgSize;
    q = 2'((p >> 30) & 3);
    t = p & ((64'd1 << 30) - 1);
    s = qsin(t);
    c = qsin((64'd1 << 30) - t);
    case (q)
      2'd0: begin co = c; si = s; end
      2'd1: begin co = -s; si = c; end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
    return {co, si};
  endfunction

  logic signed [2*TrigW-1:0] rom [ImgSize];
  for (genvar g = 0; g < ImgSize; g++) begin : g_rom
    assign rom[g] = trig_entry(g);
  end

  // registered table read
  always_ff @(posedge clk_i) begin
    cos_o <= rom[ang_i][2*TrigW-1:TrigW];
    sin_o <= rom[ang_i][TrigW-1:0];
  end

endmodule

// ----- rtl/circular_image_polar_unwrap_unit.sv -----
// channel  | ports                               | direction | transfer
// config   | inverse_scale_we_i, _i              | in        | we high at edge
// command  | func_i, row_i, col_i, pixel_in_i    | in        | start_i & !busy_o
// result   | pixel_out_o                         | out       | done_o for one cycle
// A load is taken at its accepting edge; loads can follow every cycle while busy_o
// is low. A read keeps busy_o high: the radius on its own multiplier, r*cos and r*sin
// on one shared multiplier, then one image memory read a cycle for the four
// neighbours, each weighted and summed in the cycle after its read, then rounding and clamping to
// 255. done_o follows; a read outside the image skips these steps and returns 0.
// Reset sets inverse_scale to 0.5; the image store is undefined until loaded.
// The receiver cannot stall; busy_o holds off new commands while a read runs.
module circular_image_polar_unwrap_unit import cipu_pkg::*; #(
  parameter int unsigned ImgSize = 512,
  parameter int unsigned CoordFracBits = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              inverse_scale_we_i,
  input  logic [ScaleW-1:0] inverse_scale_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              func_i,
  input  logic [PosW-1:0]   row_i,
  input  logic [PosW-1:0]   col_i,
  input  logic [PixW-1:0]   pixel_in_i,
  output logic              done_o,
  output logic [PixW-1:0]   pixel_out_o
);

  localparam int unsigned AngW = $clog2(ImgSize);
  localparam int unsigned AddrW = 2 * AngW;
  localparam int unsigned F = CoordFracBits;
  localparam int unsigned RW = AngW + 1 + ScaleW;   // radius width
  localparam int unsigned PW = RW + TrigW;          // product width
  localparam int unsigned CW = PW - 31 + F + 2;     // coordinate width
  localparam int unsigned WW = F + 1;               // weight width
  localparam int unsigned AW = PixW + 2 * WW + 2;   // accumulator width
  localparam logic signed [CW-1:0] Cen =
    CW'((ImgSize / 2) * (1 << F) - (1 << (F - 1)));

  state_e state_q, state_d;
  logic [ScaleW-1:0] scale_q;
  logic [AngW-1:0] ang_q;
  logic [AngW:0] rad_n_q;
  logic [RW-1:0] r_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [1:0] nb_q;
  logic [AW-1:0] acc_q;
  logic oob_q, fvalid_q;
  logic [PixW-1:0] out_q;
  logic signed [TrigW-1:0] cos_w, sin_w;

  cipu_trig_rom #(.ImgSize(ImgSize), .AngW(AngW)) u_trig (
    .clk_i (clk_i),
    .ang_i (ang_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  logic start_ok;
  assign start_ok = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (inverse_scale_we_i) begin
      scale_q <= inverse_scale_i;
    end
  end

  // shared multiplier: r*cos, then r*sin
  logic signed [PW-1:0] prod;
  logic signed [TrigW-1:0] trig_sel;
  always_comb begin
    trig_sel = (state_q == StSin) ? sin_w : cos_w;
    prod = $signed({1'b0, r_q}) * trig_sel;
  end
  logic signed [CW-1:0] coord;
  logic signed [PW-1:0] prod_rnd;
  assign prod_rnd = (prod + (PW'(1) <<< (30 - F))) >>> (31 - F);
  assign coord = CW'(prod_rnd) + Cen;

  // neighbour selection
  logic signed [CW-F-1:0] x0, y0, nx, ny;
  logic [F-1:0] fa, fb;
  logic [WW-1:0] wx, wy;
  logic nb_in;
  assign x0 = cx_q[CW-1:F];
  assign y0 = cy_q[CW-1:F];
  assign fa = cx_q[F-1:0];
  assign fb = cy_q[F-1:0];
  always_comb begin
    nx = x0 + (CW-F)'(nb_q[0]);
    ny = y0 + (CW-F)'(nb_q[1]);
    wx = nb_q[0] ? WW'(fa) : WW'(1 << F) - WW'(fa);
    wy = nb_q[1] ? WW'(fb) : WW'(1 << F) - WW'(fb);
    nb_in = (nx >= 0) && (ny >= 0) && (nx < ImgSize) && (ny < ImgSize);
  end

  // image memory: a write port for loads and a separate read port for the neighbours
  logic [PixW-1:0] mem [ImgSize*ImgSize];
  logic [PixW-1:0] rd_q;
  logic [2*WW-1:0] wgt_q;
  logic [AddrW-1:0] wr_addr, rd_addr;
  assign wr_addr = {row_i[AngW-1:0], col_i[AngW-1:0]};
  assign rd_addr = {ny[AngW-1:0], nx[AngW-1:0]};
  always_ff @(posedge clk_i) begin
    if (start_ok && func_i == FuncLoad && row_i < ImgSize && col_i < ImgSize) begin
      mem[wr_addr] <= pixel_in_i;
    end
    rd_q <= mem[rd_addr];
    wgt_q <= wx * wy;
    fvalid_q <= nb_in;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i && func_i == FuncRead) state_d = StRad;
      StRad:   state_d = oob_q ? StOut : StCos;
      StCos:   state_d = StSin;
      StSin:   state_d = StFetch;
      StFetch: state_d = StAcc;
      StAcc:   if (nb_q == 2'd0) state_d = StDone;
      StDone:  state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic [AW-1:0] acc_rnd;
  assign acc_rnd = (acc_q + AW'(1 << (2 * F - 1))) >> (2 * F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= (state_q == StOut);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        ang_q <= AngW'(ImgSize - 1) - row_i[AngW-1:0];
        rad_n_q <= (AngW+1)'(ImgSize) - (AngW+1)'(col_i);
        oob_q <= (row_i >= ImgSize) || (col_i >= ImgSize);
        acc_q <= '0;
        nb_q <= 2'd0;
      end
      StRad: begin
        r_q <= RW'(rad_n_q * scale_q);
        out_q <= '0;
      end
      StCos: cx_q <= coord;
      StSin: begin
        cy_q <= coord;
        nb_q <= 2'd0;
      end
      StFetch: nb_q <= nb_q + 2'd1;
      StAcc: begin
        if (fvalid_q) acc_q <= acc_q + AW'(rd_q * wgt_q);
        if (nb_q != 2'd0) nb_q <= nb_q + 2'd1;
      end
      StDone: out_q <= (acc_rnd > AW'(255)) ? PixW'(255) : acc_rnd[PixW-1:0];
      StOut: ;
      default: ;
    endcase
  end

  assign pixel_out_o = out_q;

endmodule
